@@ design/smbus_thermal_sensor_registers_macros.svh @@
`ifndef SMBUS_THERMAL_SENSOR_REGISTERS_MACROS_SVH
`define SMBUS_THERMAL_SENSOR_REGISTERS_MACROS_SVH

// Same-cycle implication, off while reset is asserted.
`define STSR_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, off while reset is asserted.
`define STSR_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

// Next-cycle implication that also runs through reset.
`define STSR_ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("reset-time check failed");

`endif

@@ design/stsr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package stsr_pkg;

    typedef enum logic [1:0] {
        OP_WRITE_START = 2'd0,
        OP_WRITE_DATA  = 2'd1,
        OP_READ        = 2'd2,
        OP_SET_TEMP    = 2'd3
    } opcode_t;

    // Register map
    localparam logic [7:0] ADDR_TEMP_INT   = 8'h01;
    localparam logic [7:0] ADDR_HIGH_INT   = 8'h07;
    localparam logic [7:0] ADDR_LOW_INT    = 8'h08;
    localparam logic [7:0] ADDR_TEMP_FRAC  = 8'h10;
    localparam logic [7:0] ADDR_HIGH_FRAC  = 8'h13;
    localparam logic [7:0] ADDR_LOW_FRAC   = 8'h14;
    localparam logic [7:0] ADDR_END        = 8'h15;
    localparam logic [7:0] READ_PAST_END   = 8'hFF;

    // Temperature conversion
    localparam logic [17:0] TEMP_MAX_MC    = 18'd255875;
    // floor(t / 125) == (t * RECIP_125) >> RECIP_SHIFT for every 18-bit t
    localparam int          RECIP_SHIFT    = 25;
    localparam logic [18:0] RECIP_125      = 19'd268436;
    localparam int          EIGHTHS_W      = 12;

    // Reset values
    localparam logic [7:0] RST_TEMP_INT    = 8'd45;
    localparam logic [2:0] RST_TEMP_FRAC   = 3'd4;
    localparam logic [7:0] RST_HIGH_INT    = 8'd255;

    typedef struct packed {
        opcode_t    opcode;
        logic [7:0] data_byte;
    } cmd_t;

    typedef struct packed {
        logic       over_range;
        logic [7:0] whole;
        logic [2:0] eighths;
    } temp_upd_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       error;
    } rsp_t;

endpackage

`default_nettype wire

@@ design/stsr_temp_conv.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stsr_temp_conv
    import stsr_pkg::*;
(
    input  wire logic [17:0] temp_millideg,
    output temp_upd_t        upd
);

    logic [36:0]          prod;
    logic [EIGHTHS_W-1:0] eighths_total;

    // floor(t / 125) gives whole degrees in the upper bits and eighths below
    assign prod          = {19'd0, temp_millideg} * {18'd0, RECIP_125};
    assign eighths_total = prod[RECIP_SHIFT +: EIGHTHS_W];

    assign upd.over_range = (temp_millideg > TEMP_MAX_MC);
    assign upd.whole      = eighths_total[10:3];
    assign upd.eighths    = eighths_total[2:0];

endmodule

`default_nettype wire

@@ design/stsr_regfile.sv @@
`timescale 1ns / 1ps
`default_nettype none

module stsr_regfile
    import stsr_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      fire,
    input  wire cmd_t      cmd,
    input  wire temp_upd_t upd,
    output rsp_t           rsp
);

    logic [7:0] pointer_reg,   pointer_next;
    logic [7:0] temp_int_reg,  temp_int_next;
    logic [2:0] temp_frac_reg, temp_frac_next;
    logic [7:0] high_int_reg,  high_int_next;
    logic [7:0] low_int_reg,   low_int_next;
    logic [7:0] high_frac_reg, high_frac_next;
    logic [7:0] low_frac_reg,  low_frac_next;
    logic [7:0] read_byte;

    always_comb begin
        if (pointer_reg >= ADDR_END) begin
            read_byte = READ_PAST_END;
        end else begin
            case (pointer_reg)
                ADDR_TEMP_INT:  read_byte = temp_int_reg;
                ADDR_HIGH_INT:  read_byte = high_int_reg;
                ADDR_LOW_INT:   read_byte = low_int_reg;
                ADDR_TEMP_FRAC: read_byte = {temp_frac_reg, 5'd0};
                ADDR_HIGH_FRAC: read_byte = high_frac_reg;
                ADDR_LOW_FRAC:  read_byte = low_frac_reg;
                default:        read_byte = 8'd0;
            endcase
        end
    end

    always_comb begin
        pointer_next   = pointer_reg;
        temp_int_next  = temp_int_reg;
        temp_frac_next = temp_frac_reg;
        high_int_next  = high_int_reg;
        low_int_next   = low_int_reg;
        high_frac_next = high_frac_reg;
        low_frac_next  = low_frac_reg;
        rsp            = '0;
        case (cmd.opcode)
            OP_WRITE_START: begin
                pointer_next = cmd.data_byte;
            end
            OP_WRITE_DATA: begin
                pointer_next = pointer_reg + 8'd1;
                case (pointer_reg)
                    ADDR_HIGH_INT:  high_int_next  = cmd.data_byte;
                    ADDR_LOW_INT:   low_int_next   = cmd.data_byte;
                    ADDR_HIGH_FRAC: high_frac_next = cmd.data_byte;
                    ADDR_LOW_FRAC:  low_frac_next  = cmd.data_byte;
                    default:        rsp.error      = 1'b1;
                endcase
            end
            OP_READ: begin
                pointer_next  = pointer_reg + 8'd1;
                rsp.read_data = read_byte;
            end
            OP_SET_TEMP: begin
                if (upd.over_range) begin
                    rsp.error = 1'b1;
                end else begin
                    temp_int_next  = upd.whole;
                    temp_frac_next = upd.eighths;
                end
            end
            default: begin
                rsp = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pointer_reg   <= 8'd0;
            temp_int_reg  <= RST_TEMP_INT;
            temp_frac_reg <= RST_TEMP_FRAC;
            high_int_reg  <= RST_HIGH_INT;
            low_int_reg   <= 8'd0;
            high_frac_reg <= 8'd0;
            low_frac_reg  <= 8'd0;
        end else if (fire) begin
            pointer_reg   <= pointer_next;
            temp_int_reg  <= temp_int_next;
            temp_frac_reg <= temp_frac_next;
            high_int_reg  <= high_int_next;
            low_int_reg   <= low_int_next;
            high_frac_reg <= high_frac_next;
            low_frac_reg  <= low_frac_next;
        end
    end

endmodule

`default_nettype wire

@@ design/smbus_thermal_sensor_registers.sv @@
// Register file of a bus-attached temperature sensor. Each input transaction
// carries one bus event, selected by s_axis_tuser: a write start that loads the
// register pointer, a data byte written at the pointer (only the four limit
// registers 0x07, 0x08, 0x13, 0x14 take it; anything else drops the byte and
// flags an error), a read at the pointer (0xFF from 0x15 up), or a temperature
// update in millidegrees (above 255875 it is rejected with an error). Writes
// and reads advance the pointer, wrapping at 256. Every input transaction gives
// exactly one result transaction with the read byte (zero unless a read) and
// the error flag. The block takes one transaction per clock while the output
// keeps draining: an input register feeds a single pass of logic (pointer
// decode and one constant multiply for the divide by 125) into an output
// register that presents the result. s_axis_tready stays high while the output
// register is empty or being drained; when m_axis_tready drops, one more
// transaction is held in the input register before s_axis_tready falls.
// After reset the temperature reads 45.5 C and the high limit integer 255.
`timescale 1ns / 1ps
`default_nettype none

module smbus_thermal_sensor_registers
    import stsr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [7:0] data_byte, [25:8] temp_millideg, zero pad
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] opcode

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] read_data
    output logic [0:0]       m_axis_tuser    // [0] error
);

    logic        s_accept;
    logic        advance;

    // Input register
    logic        in_vld_reg,  in_vld_next;
    opcode_t     in_op_reg;
    logic [7:0]  in_data_reg;
    logic [17:0] in_temp_reg;

    // Output register
    logic        out_vld_reg, out_vld_next;
    rsp_t        out_rsp_reg;

    cmd_t        cmd;
    temp_upd_t   upd;
    rsp_t        rsp;

    // Move the held transaction forward when the output register is free or
    // draining this cycle.
    assign advance       = in_vld_reg && (!out_vld_reg || m_axis_tready);
    assign s_axis_tready = !in_vld_reg || !out_vld_reg || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign cmd.opcode    = in_op_reg;
    assign cmd.data_byte = in_data_reg;

    stsr_temp_conv u_conv (
        .temp_millideg (in_temp_reg),
        .upd           (upd)
    );

    // State only changes when the transaction moves into the output register.
    stsr_regfile u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (advance),
        .cmd     (cmd),
        .upd     (upd),
        .rsp     (rsp)
    );

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_accept) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end
    end

    always_comb begin
        out_vld_next = out_vld_reg;
        if (advance) begin
            out_vld_next = 1'b1;
        end else if (m_axis_tready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload registers: load on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg   <= opcode_t'(s_axis_tuser);
            in_data_reg <= s_axis_tdata[7:0];
            in_temp_reg <= s_axis_tdata[25:8];
        end
        if (advance) begin
            out_rsp_reg <= rsp;
        end
    end

    assign m_axis_tvalid   = out_vld_reg;
    assign m_axis_tdata    = out_rsp_reg.read_data;
    assign m_axis_tuser[0] = out_rsp_reg.error;

endmodule

`default_nettype wire

@@ design/stsr_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "smbus_thermal_sensor_registers_macros.svh"

module stsr_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser
);

    // A stalled result holds its payload.
    `STSR_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // No result is pending right after reset.
    `STSR_ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_axis_tvalid)

    // Errors only come from data writes and temperature updates, never reads.
    `STSR_ASSERT_IMP(a_err_no_data, aclk, aresetn, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == 8'd0)

    // With the output side empty the input side must take a transaction.
    `STSR_ASSERT_IMP(a_ready_when_empty, aclk, aresetn, !m_axis_tvalid, s_axis_tready)

endmodule

bind smbus_thermal_sensor_registers stsr_checker u_stsr_checker (.*);

`default_nettype wire

@@ sim/smbus_thermal_sensor_registers_tb.sv @@
`timescale 1ns / 1ps

module smbus_thermal_sensor_registers_tb;
    import stsr_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int RESET_CYCLES  = 7;
    localparam int IDLE_LIMIT    = 3000;  // cycles with no transaction on either side
    localparam int DRAIN_CYCLES  = 12;    // drains the input and output registers, plus margin
    localparam int RANDOM_ITEMS  = 800;
    localparam int HOLD_AT_COUNT = 250;   // results seen before the long output stall
    localparam int HOLD_CYCLES   = 150;
    localparam int MAX_REPORTS   = 10;

    // One bus event or temperature update as offered on the input channel.
    typedef struct {
        opcode_t     op;
        logic [7:0]  data_byte;
        logic [17:0] temp_mc;
        bit          drain;     // wait for every outstanding result before offering
    } bus_evt_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = OP_WRITE_START;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    smbus_thermal_sensor_registers dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Shadow of the sensor register file, advanced once per accepted transaction.
    logic [7:0] sh_pointer;
    logic [7:0] sh_temp_int;
    logic [2:0] sh_temp_eighths;
    logic [7:0] sh_high_int;
    logic [7:0] sh_low_int;
    logic [7:0] sh_high_frac;
    logic [7:0] sh_low_frac;

    bus_evt_t evt_q[$];          // events waiting to be offered
    rsp_t     rsp_expect_q[$];   // responses owed by the block, oldest first

    int total_items  = 0;
    int in_count     = 0;
    int out_count    = 0;
    int rsp_pending  = 0;
    int idle_cycles  = 0;
    int fail_count   = 0;
    bit in_fire      = 1'b0;
    bit m_fire       = 1'b0;

    // Coverage tallies for the closing summary
    int n_ptr_loads  = 0;
    int n_reads      = 0;
    int n_writes     = 0;
    int n_refused    = 0;
    int n_temps      = 0;
    int n_over_range = 0;

    function automatic void shadow_reset();
        sh_pointer      = 8'd0;
        sh_temp_int     = 8'd45;
        sh_temp_eighths = 3'd4;
        sh_high_int     = 8'd255;
        sh_low_int      = 8'd0;
        sh_high_frac    = 8'd0;
        sh_low_frac     = 8'd0;
    endfunction

    // Apply one event to the shadow registers and return the response it owes.
    function automatic rsp_t sensor_step(opcode_t op, logic [7:0] d, logic [17:0] t);
        rsp_t r;
        int   tv;
        r  = '0;
        tv = int'(t);
        case (op)
            OP_WRITE_START: begin
                sh_pointer = d;
            end
            OP_WRITE_DATA: begin
                case (sh_pointer)
                    ADDR_HIGH_INT:  sh_high_int  = d;
                    ADDR_LOW_INT:   sh_low_int   = d;
                    ADDR_HIGH_FRAC: sh_high_frac = d;
                    ADDR_LOW_FRAC:  sh_low_frac  = d;
                    default:        r.error      = 1'b1;
                endcase
                sh_pointer = sh_pointer + 8'd1;
            end
            OP_READ: begin
                if (sh_pointer >= ADDR_END) begin
                    r.read_data = READ_PAST_END;
                end else begin
                    case (sh_pointer)
                        ADDR_TEMP_INT:  r.read_data = sh_temp_int;
                        ADDR_HIGH_INT:  r.read_data = sh_high_int;
                        ADDR_LOW_INT:   r.read_data = sh_low_int;
                        ADDR_TEMP_FRAC: r.read_data = {sh_temp_eighths, 5'b0};
                        ADDR_HIGH_FRAC: r.read_data = sh_high_frac;
                        ADDR_LOW_FRAC:  r.read_data = sh_low_frac;
                        default:        r.read_data = 8'h00;
                    endcase
                end
                sh_pointer = sh_pointer + 8'd1;
            end
            default: begin
                if (tv > 255875) begin
                    r.error = 1'b1;
                end else begin
                    sh_temp_int     = 8'(tv / 1000);
                    sh_temp_eighths = 3'((tv % 1000) / 125);
                end
            end
        endcase
        return r;
    endfunction

    function automatic void push_evt(opcode_t op, logic [7:0] d, logic [17:0] t);
        bus_evt_t e;
        e.op        = op;
        e.data_byte = d;
        e.temp_mc   = t;
        e.drain     = 1'b0;
        evt_q.push_back(e);
    endfunction

    // Gap before the next transaction: mostly none or short, a few long.
    function automatic int pick_gap(bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Pointer values: lean on the map edges, the limit registers and the wrap.
    function automatic logic [7:0] pick_addr();
        logic [7:0] hot [12];
        hot = '{8'h00, 8'h01, 8'h07, 8'h08, 8'h10, 8'h12,
                8'h13, 8'h14, 8'h15, 8'h16, 8'hFE, 8'hFF};
        if ($urandom_range(0, 9) < 6)
            return hot[$urandom_range(0, 11)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [17:0] pick_temp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 18'($urandom_range(0, 255875));
        else if (r < 50)
            return 18'($urandom_range(255860, 255890));
        else if (r < 60)
            return 18'($urandom_range(0, 1999));
        else if (r < 75)
            return 18'($urandom_range(255876, 262143));
        else
            return 18'($urandom_range(0, 262143));
    endfunction

    function automatic void flag_fault(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endfunction

    // Fill the event queue: directed corner cases first, then random bus traffic.
    initial begin : stimulus
        int kind;
        int n;
        int k;

        // Reset values: zero at pointer zero, temperature 45.5 C
        push_evt(OP_READ, 8'h5C, 18'($urandom_range(0, 262143)));
        push_evt(OP_WRITE_START, ADDR_TEMP_INT, 18'h3FFFF);
        push_evt(OP_READ, 8'hFF, 18'd0);
        push_evt(OP_WRITE_START, ADDR_TEMP_FRAC, 18'd0);
        push_evt(OP_READ, 8'h00, 18'd0);
        // Limit writes, auto-increment, and a refused write past the low limit
        push_evt(OP_WRITE_START, ADDR_HIGH_INT, 18'd0);
        push_evt(OP_WRITE_DATA, 8'hA5, 18'h3FFFF);
        push_evt(OP_WRITE_DATA, 8'h5A, 18'd0);
        push_evt(OP_WRITE_DATA, 8'hFF, 18'd0);
        push_evt(OP_WRITE_START, ADDR_HIGH_FRAC, 18'd0);
        push_evt(OP_WRITE_DATA, 8'hFF, 18'd0);
        push_evt(OP_WRITE_DATA, 8'h00, 18'd0);
        push_evt(OP_WRITE_DATA, 8'h3C, 18'd0);
        // Read back across the end of the map
        push_evt(OP_WRITE_START, ADDR_HIGH_FRAC, 18'd0);
        push_evt(OP_READ, 8'h00, 18'd0);
        push_evt(OP_READ, 8'h00, 18'd0);
        push_evt(OP_READ, 8'h00, 18'd0);
        // Pointer wrap on read and on a refused write
        push_evt(OP_WRITE_START, 8'hFF, 18'd0);
        push_evt(OP_READ, 8'h00, 18'd0);
        push_evt(OP_WRITE_START, 8'hFF, 18'd0);
        push_evt(OP_WRITE_DATA, 8'h81, 18'd0);
        // Temperature extremes, both sides of the range limit
        push_evt(OP_SET_TEMP, 8'h00, 18'd0);
        push_evt(OP_SET_TEMP, 8'hFF, 18'd255875);
        push_evt(OP_SET_TEMP, 8'h00, 18'd255876);
        push_evt(OP_SET_TEMP, 8'h00, 18'h3FFFF);
        push_evt(OP_SET_TEMP, 8'h00, 18'd999);

        while (evt_q.size() < 26 + RANDOM_ITEMS) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                // write transaction: pointer load then a burst of data bytes
                push_evt(OP_WRITE_START, pick_addr(), 18'($urandom_range(0, 262143)));
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++)
                    push_evt(OP_WRITE_DATA, 8'($urandom_range(0, 255)),
                             18'($urandom_range(0, 262143)));
            end else if (kind < 70) begin
                // read transaction, usually re-addressed, sometimes continuing
                if ($urandom_range(0, 9) < 7)
                    push_evt(OP_WRITE_START, pick_addr(), 18'($urandom_range(0, 262143)));
                n = $urandom_range(1, 4);
                for (k = 0; k < n; k++)
                    push_evt(OP_READ, 8'($urandom_range(0, 255)),
                             18'($urandom_range(0, 262143)));
            end else if (kind < 88) begin
                push_evt(OP_SET_TEMP, 8'($urandom_range(0, 255)), pick_temp());
            end else begin
                push_evt(opcode_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         18'($urandom_range(0, 262143)));
            end
        end
        // Let the pipeline run dry twice mid-stream
        evt_q[400].drain = 1'b1;
        evt_q[600].drain = 1'b1;
        total_items = evt_q.size();

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        wait (in_count == total_items);
        wait (rsp_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d transactions: %0d pointer loads, %0d reads,",
                 in_count, n_ptr_loads, n_reads);
        $display("  %0d data writes (%0d refused), %0d temperature updates (%0d over range),",
                 n_writes, n_refused, n_temps, n_over_range);
        $display("  with a long output stall and a full drain.");
        if (fail_count == 0 && rsp_expect_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Sample both channels at the rising edge: check responses, then predict
    // the response for any input transaction accepted at this edge.
    always @(posedge aclk) begin : monitor
        rsp_t     exp_rsp;
        rsp_t     new_rsp;
        opcode_t  op;
        in_fire = s_axis_tvalid && s_axis_tready;
        m_fire  = m_axis_tvalid && m_axis_tready;
        if (!aresetn) begin
            shadow_reset();
            idle_cycles = 0;
        end else begin
            if (m_fire) begin
                out_count++;
                if (rsp_expect_q.size() == 0) begin
                    flag_fault($sformatf("response with none pending: data=%02h error=%0d",
                                         m_axis_tdata, m_axis_tuser[0]));
                end else begin
                    exp_rsp = rsp_expect_q.pop_front();
                    if (m_axis_tdata !== exp_rsp.read_data ||
                        m_axis_tuser[0] !== exp_rsp.error)
                        flag_fault($sformatf(
                            "response %0d: expected data=%02h error=%0d, got data=%02h error=%0d",
                            out_count, exp_rsp.read_data, exp_rsp.error,
                            m_axis_tdata, m_axis_tuser[0]));
                end
            end
            if (in_fire) begin
                op      = opcode_t'(s_axis_tuser);
                new_rsp = sensor_step(op, s_axis_tdata[7:0], s_axis_tdata[25:8]);
                rsp_expect_q.push_back(new_rsp);
                in_count++;
                case (op)
                    OP_WRITE_START: n_ptr_loads++;
                    OP_READ:        n_reads++;
                    OP_WRITE_DATA: begin
                        n_writes++;
                        if (new_rsp.error) n_refused++;
                    end
                    default: begin
                        n_temps++;
                        if (new_rsp.error) n_over_range++;
                    end
                endcase
            end
            rsp_pending = rsp_expect_q.size();
            if (in_fire || m_fire)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
    end

    // Input driver: hold an offered transaction until accepted, then advance
    // to the next event after a random gap. Drive at the falling edge only.
    int  tx_gap    = 0;
    int  tx_cycles = 0;
    bit  tx_steady = 1'b0;

    always @(negedge aclk) begin : driver
        bus_evt_t cur;
        logic     nxt_valid;
        tx_cycles++;
        if (tx_cycles % 170 == 0)
            tx_steady = ($urandom_range(0, 3) == 0);
        if (aresetn && !(s_axis_tvalid && !in_fire)) begin
            nxt_valid = 1'b0;
            if (tx_gap > 0) begin
                tx_gap--;
            end else if (evt_q.size() != 0 && !(evt_q[0].drain && rsp_pending != 0)) begin
                cur = evt_q.pop_front();
                s_axis_tuser <= cur.op;
                s_axis_tdata <= {6'b0, cur.temp_mc, cur.data_byte};
                nxt_valid    = 1'b1;
                tx_gap       = pick_gap(tx_steady);
            end
            s_axis_tvalid <= nxt_valid;
        end
    end

    // Output receiver: random stalls after each response, plus one long
    // hold-off so the block backs up and drops s_axis_tready.
    int  rx_gap    = 0;
    int  rx_cycles = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  rx_steady = 1'b0;

    always @(negedge aclk) begin : receiver
        logic ready_n;
        rx_cycles++;
        if (rx_cycles % 150 == 0)
            rx_steady = ($urandom_range(0, 3) == 0);
        if (!hold_done && out_count >= HOLD_AT_COUNT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            ready_n = 1'b0;
        end else begin
            if (m_fire)
                rx_gap = pick_gap(rx_steady);
            if (rx_gap > 0) begin
                rx_gap--;
                ready_n = 1'b0;
            end else begin
                ready_n = 1'b1;
            end
        end
        m_axis_tready <= aresetn ? ready_n : 1'b0;
    end

    // Watchdog: end the run if neither channel moves for too long.
    initial begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("Timeout: no transaction for %0d cycles (%0d of %0d accepted, %0d pending)",
                 IDLE_LIMIT, in_count, total_items, rsp_pending);
        $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/stsr_pkg.sv
design/stsr_temp_conv.sv
design/stsr_regfile.sv
design/smbus_thermal_sensor_registers.sv
design/stsr_checker.sv
sim/smbus_thermal_sensor_registers_tb.sv
